// ===== rtl/core/alsc_pkg.sv =====
`timescale 1ns / 1ps
// Types and character constants for the ambient line syntax checker.
// Has no dependencies; every other file of the block refers to it by scoped names.

package alsc_pkg;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_IDENT   = 8'h41;
    localparam logic [7:0] CHAR_POINT   = 8'h2E;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    typedef enum logic [3:0] {
        ST_START  = 4'd0,
        ST_IDENT  = 4'd1,
        ST_SP1    = 4'd2,
        ST_INT    = 4'd3,
        ST_POINT  = 4'd4,
        ST_FRAC   = 4'd5,
        ST_SP2    = 4'd6,
        ST_RED    = 4'd7,
        ST_COMMA1 = 4'd8,
        ST_GREEN  = 4'd9,
        ST_COMMA2 = 4'd10,
        ST_BLUE   = 4'd11,
        ST_SP3    = 4'd12,
        ST_ACCEPT = 4'd13,
        ST_REJECT = 4'd14
    } t_parse_state;

    typedef enum logic [1:0] {
        VERDICT_RUNNING  = 2'd0,
        VERDICT_ACCEPTED = 2'd1,
        VERDICT_REJECTED = 2'd2
    } t_verdict;

    typedef struct packed {
        t_parse_state parse_state;
        t_verdict     verdict;
    } t_step_result;

endpackage

// ===== rtl/core/alsc_step.sv =====
`timescale 1ns / 1ps
// Transition logic of the ambient line recognizer: one byte, one state step.
// Purely combinational; depends on alsc_pkg.

module alsc_step (
    input  alsc_pkg::t_parse_state i_state,
    input  logic [7:0]             i_char,
    input  logic                   i_restart,
    output alsc_pkg::t_step_result o_result
);

    alsc_pkg::t_parse_state w_from;
    alsc_pkg::t_parse_state w_to;
    logic                   w_sp;
    logic                   w_dg;
    logic                   w_nl;
    logic                   w_comma;

    assign w_sp    = (i_char == alsc_pkg::CHAR_SPACE);
    assign w_dg    = (i_char >= alsc_pkg::CHAR_ZERO) && (i_char <= alsc_pkg::CHAR_NINE);
    assign w_nl    = (i_char == alsc_pkg::CHAR_NEWLINE);
    assign w_comma = (i_char == alsc_pkg::CHAR_COMMA);
    assign w_from  = i_restart ? alsc_pkg::ST_START : i_state;

    always_comb begin
        w_to = alsc_pkg::ST_REJECT;
        unique case (w_from)
            alsc_pkg::ST_START: begin
                if (w_sp) w_to = alsc_pkg::ST_START;
                else if (i_char == alsc_pkg::CHAR_IDENT) w_to = alsc_pkg::ST_IDENT;
            end
            alsc_pkg::ST_IDENT: begin
                if (w_sp) w_to = alsc_pkg::ST_SP1;
            end
            alsc_pkg::ST_SP1: begin
                if (w_sp) w_to = alsc_pkg::ST_SP1;
                else if (w_dg) w_to = alsc_pkg::ST_INT;
            end
            alsc_pkg::ST_INT: begin
                if (w_sp) w_to = alsc_pkg::ST_SP2;
                else if (i_char == alsc_pkg::CHAR_POINT) w_to = alsc_pkg::ST_POINT;
            end
            alsc_pkg::ST_POINT: begin
                if (w_dg) w_to = alsc_pkg::ST_FRAC;
            end
            alsc_pkg::ST_FRAC: begin
                if (w_sp) w_to = alsc_pkg::ST_SP2;
                else if (w_dg) w_to = alsc_pkg::ST_FRAC;
            end
            alsc_pkg::ST_SP2: begin
                if (w_sp) w_to = alsc_pkg::ST_SP2;
                else if (w_dg) w_to = alsc_pkg::ST_RED;
            end
            alsc_pkg::ST_RED: begin
                if (w_comma) w_to = alsc_pkg::ST_COMMA1;
                else if (w_dg) w_to = alsc_pkg::ST_RED;
            end
            alsc_pkg::ST_COMMA1: begin
                if (w_dg) w_to = alsc_pkg::ST_GREEN;
            end
            alsc_pkg::ST_GREEN: begin
                if (w_comma) w_to = alsc_pkg::ST_COMMA2;
                else if (w_dg) w_to = alsc_pkg::ST_GREEN;
            end
            alsc_pkg::ST_COMMA2: begin
                if (w_dg) w_to = alsc_pkg::ST_BLUE;
            end
            alsc_pkg::ST_BLUE: begin
                if (w_dg) w_to = alsc_pkg::ST_BLUE;
                else if (w_nl) w_to = alsc_pkg::ST_ACCEPT;
                else if (w_sp) w_to = alsc_pkg::ST_SP3;
            end
            alsc_pkg::ST_SP3: begin
                if (w_sp) w_to = alsc_pkg::ST_SP3;
                else if (w_nl) w_to = alsc_pkg::ST_ACCEPT;
            end
            alsc_pkg::ST_ACCEPT: begin
                w_to = alsc_pkg::ST_ACCEPT;
            end
            default: begin
                w_to = alsc_pkg::ST_REJECT;
            end
        endcase
    end

    always_comb begin
        o_result.parse_state = w_to;
        if (w_to == alsc_pkg::ST_ACCEPT) begin
            o_result.verdict = alsc_pkg::VERDICT_ACCEPTED;
        end else if (w_to == alsc_pkg::ST_REJECT) begin
            o_result.verdict = alsc_pkg::VERDICT_REJECTED;
        end else begin
            o_result.verdict = alsc_pkg::VERDICT_RUNNING;
        end
    end

endmodule

// ===== rtl/core/ambient_line_syntax_checker_core.sv =====
`timescale 1ns / 1ps
// Top level of the ambient line syntax checker: input register, recognizer state,
// result register. Depends on alsc_pkg and alsc_step.
//
// Usage:
//   Bytes of one ambient-light line enter on the slave stream, one item per byte,
//   with tdata carrying the byte and tuser the restart flag. A restart of one
//   returns the recognizer to the start state before that byte is consumed.
//   Every input item yields exactly one result item on the master stream,
//   carrying the verdict (running, accepted, rejected) and the new state code.
//   Accept and reject hold until a restart.
//   After acceptance the item waits in the input register and moves into the result
//   register, where it is offered, once that register is free or being emptied.
//   One item is taken every cycle while the receiver keeps up;
//   the figure is set by the single state register, updated as each item moves
//   from the input register into the result register.
//   When the receiver stalls, the result register holds its item and the input
//   register takes one further item, after which tready falls until the result
//   is taken. Reset empties both registers and puts the recognizer in the start
//   state.

module ambient_line_syntax_checker_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_in
    input  logic [0:0] i_s_axis_tuser,   // [0] restart
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata    // [1:0] verdict, [5:2] parse_state, [7:6] zero
);

    logic                   r_in_valid;
    logic [7:0]             r_char;
    logic                   r_restart;
    alsc_pkg::t_parse_state r_state;
    logic                   r_out_valid;
    alsc_pkg::t_step_result r_out;
    alsc_pkg::t_step_result n_step;
    logic                   w_advance;
    logic                   w_take;

    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    alsc_step u_step (
        .i_state   (r_state),
        .i_char    (r_char),
        .i_restart (r_restart),
        .o_result  (n_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= alsc_pkg::ST_START;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_advance) begin
                r_state     <= n_step.parse_state;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_char    <= i_s_axis_tdata;
            r_restart <= i_s_axis_tuser[0];
        end
        if (w_advance) begin
            r_out <= n_step;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.parse_state, r_out.verdict};

endmodule

// ===== verif/ambient_line_syntax_checker_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ambient_line_syntax_checker_core: feeds whole, broken and noisy
// ambient-light lines byte by byte and compares every result item with its own recognizer.
// Depends on alsc_pkg and the RTL of the core; needs no files or arguments.

module ambient_line_syntax_checker_core_tb;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'h00;
    logic [0:0] i_s_axis_tuser = 1'b0;
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;

    alsc_pkg::t_parse_state line_state = alsc_pkg::ST_START;
    alsc_pkg::t_step_result expected_steps[$];
    alsc_pkg::t_step_result oldest_step;
    logic [7:0]   line_buf[$];
    int           mismatch_count = 0;
    int           items_sent = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;

    ambient_line_syntax_checker_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic alsc_pkg::t_parse_state advance_line_state(alsc_pkg::t_parse_state s,
                                                                  logic [7:0] b);
        logic                   sp;
        logic                   dg;
        alsc_pkg::t_parse_state n;
        sp = (b == alsc_pkg::CHAR_SPACE);
        dg = (b >= alsc_pkg::CHAR_ZERO) && (b <= alsc_pkg::CHAR_NINE);
        n  = alsc_pkg::ST_REJECT;
        case (s)
            alsc_pkg::ST_START: begin
                if (sp) n = alsc_pkg::ST_START;
                else if (b == alsc_pkg::CHAR_IDENT) n = alsc_pkg::ST_IDENT;
            end
            alsc_pkg::ST_IDENT: begin
                if (sp) n = alsc_pkg::ST_SP1;
            end
            alsc_pkg::ST_SP1: begin
                if (sp) n = alsc_pkg::ST_SP1;
                else if (dg) n = alsc_pkg::ST_INT;
            end
            alsc_pkg::ST_INT: begin
                if (sp) n = alsc_pkg::ST_SP2;
                else if (b == alsc_pkg::CHAR_POINT) n = alsc_pkg::ST_POINT;
            end
            alsc_pkg::ST_POINT: begin
                if (dg) n = alsc_pkg::ST_FRAC;
            end
            alsc_pkg::ST_FRAC: begin
                if (sp) n = alsc_pkg::ST_SP2;
                else if (dg) n = alsc_pkg::ST_FRAC;
            end
            alsc_pkg::ST_SP2: begin
                if (sp) n = alsc_pkg::ST_SP2;
                else if (dg) n = alsc_pkg::ST_RED;
            end
            alsc_pkg::ST_RED: begin
                if (b == alsc_pkg::CHAR_COMMA) n = alsc_pkg::ST_COMMA1;
                else if (dg) n = alsc_pkg::ST_RED;
            end
            alsc_pkg::ST_COMMA1: begin
                if (dg) n = alsc_pkg::ST_GREEN;
            end
            alsc_pkg::ST_GREEN: begin
                if (b == alsc_pkg::CHAR_COMMA) n = alsc_pkg::ST_COMMA2;
                else if (dg) n = alsc_pkg::ST_GREEN;
            end
            alsc_pkg::ST_COMMA2: begin
                if (dg) n = alsc_pkg::ST_BLUE;
            end
            alsc_pkg::ST_BLUE: begin
                if (dg) n = alsc_pkg::ST_BLUE;
                else if (b == alsc_pkg::CHAR_NEWLINE) n = alsc_pkg::ST_ACCEPT;
                else if (sp) n = alsc_pkg::ST_SP3;
            end
            alsc_pkg::ST_SP3: begin
                if (sp) n = alsc_pkg::ST_SP3;
                else if (b == alsc_pkg::CHAR_NEWLINE) n = alsc_pkg::ST_ACCEPT;
            end
            alsc_pkg::ST_ACCEPT: begin
                n = alsc_pkg::ST_ACCEPT;
            end
            default: begin
                n = alsc_pkg::ST_REJECT;
            end
        endcase
        return n;
    endfunction

    function automatic alsc_pkg::t_verdict verdict_of(alsc_pkg::t_parse_state s);
        if (s == alsc_pkg::ST_ACCEPT) return alsc_pkg::VERDICT_ACCEPTED;
        if (s == alsc_pkg::ST_REJECT) return alsc_pkg::VERDICT_REJECTED;
        return alsc_pkg::VERDICT_RUNNING;
    endfunction

    function automatic logic [7:0] pick_token_byte();
        case ($urandom_range(5))
            0: return alsc_pkg::CHAR_SPACE;
            1: return alsc_pkg::CHAR_IDENT;
            2: return alsc_pkg::CHAR_POINT;
            3: return alsc_pkg::CHAR_COMMA;
            4: return alsc_pkg::CHAR_NEWLINE;
            default: return alsc_pkg::CHAR_ZERO + 8'($urandom_range(9));
        endcase
    endfunction

    task automatic report_mismatch(string what, int observed, int predicted);
        $display("MISMATCH at %0t: %s observed %0d, predicted %0d", $time, what, observed,
                 predicted);
        mismatch_count++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic restart);
        bit accepted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= restart;
        accepted = 1'b0;
        while (!accepted) begin
            @(negedge i_clk);
            accepted = o_s_axis_tready;
            @(posedge i_clk);
        end
        if (restart) line_state = alsc_pkg::ST_START;
        line_state = advance_line_state(line_state, b);
        expected_steps.push_back('{parse_state: line_state, verdict: verdict_of(line_state)});
        items_sent++;
    endtask

    task automatic send_text(input string s, input bit restart_first);
        for (int k = 0; k < s.len(); k++) send_byte(s[k], restart_first && (k == 0));
    endtask

    task automatic push_spaces(input int lo, input int hi);
        repeat ($urandom_range(hi, lo)) line_buf.push_back(alsc_pkg::CHAR_SPACE);
    endtask

    task automatic push_digits(input int lo, input int hi);
        repeat ($urandom_range(hi, lo)) begin
            line_buf.push_back(alsc_pkg::CHAR_ZERO + 8'($urandom_range(9)));
        end
    endtask

    task automatic compose_line();
        int pos;
        line_buf = {};
        push_spaces(0, 2);
        line_buf.push_back(alsc_pkg::CHAR_IDENT);
        push_spaces(1, 3);
        push_digits(1, 1);
        if ($urandom_range(1)) begin
            line_buf.push_back(alsc_pkg::CHAR_POINT);
            push_digits(1, 3);
        end
        push_spaces(1, 3);
        for (int k = 0; k < 3; k++) begin
            if (k != 0) line_buf.push_back(alsc_pkg::CHAR_COMMA);
            push_digits(1, 3);
        end
        push_spaces(0, 2);
        line_buf.push_back(alsc_pkg::CHAR_NEWLINE);
        pos = $urandom_range(line_buf.size() - 1);
        case ($urandom_range(9))
            0: line_buf[pos] = 8'($urandom_range(255));
            1: line_buf[pos] = pick_token_byte();
            2: while (line_buf.size() > pos) void'(line_buf.pop_back());
            3: line_buf.insert(pos, pick_token_byte());
            4: line_buf.delete(pos);
            default: ;
        endcase
        if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(3, 1)) line_buf.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic test_directed_lines();
        send_text("A 1 2,3,4\n", 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(alsc_pkg::CHAR_IDENT, 1'b0);
        send_text("A 9.5 0,0,9 \n", 1'b1);
    endtask

    task automatic test_random_lines(input int sender_gap_pct, input int receiver_gap_pct,
                                     input int n_items);
        int stop_at;
        bit restart_first;
        send_idle_pct = sender_gap_pct;
        recv_idle_pct = receiver_gap_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(8, 1)) begin
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                end
            end else begin
                compose_line();
                restart_first = ($urandom_range(9) != 0);
                foreach (line_buf[k]) send_byte(line_buf[k], restart_first && (k == 0));
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_steps.size() == 0) begin
                report_mismatch("result item with nothing pending, tdata", o_m_axis_tdata, 0);
            end else begin
                oldest_step = expected_steps.pop_front();
                if (o_m_axis_tdata[1:0] !== oldest_step.verdict)
                    report_mismatch("verdict", o_m_axis_tdata[1:0], oldest_step.verdict);
                if (o_m_axis_tdata[5:2] !== oldest_step.parse_state)
                    report_mismatch("parse_state", o_m_axis_tdata[5:2], oldest_step.parse_state);
                if (o_m_axis_tdata[7:6] !== 2'b00)
                    report_mismatch("padding bits", o_m_axis_tdata[7:6], 0);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("** ambient_line_syntax_checker_core: FAILED **");
        $finish;
    end

    initial begin
        send_idle_pct = 22;
        recv_idle_pct = 88;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_lines();
        test_random_lines(22, 88, 440);
        test_random_lines(88, 22, 440);
        test_random_lines(0, 0, 440);
        i_s_axis_tvalid <= 1'b0;
        while (expected_steps.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** ambient_line_syntax_checker_core: PASSED **");
        end else begin
            $display("** ambient_line_syntax_checker_core: FAILED **");
        end
        $finish;
    end

endmodule
